@@ src/ttps_pkg.sv @@
// ttps_pkg: types, constants and helpers for the two-target position sequencer
// used by ttps_ctrl, ttps_dp and two_target_position_sequencer_top; no dependencies
`default_nettype none

package ttps_pkg;

	// field widths
	localparam int POS_W   = 24;   // center, signed q.8
	localparam int COORD_W = 23;   // target coordinate, signed q.8
	localparam int TIME_W  = 32;   // elapsed and movement timers
	localparam int REG_W   = 24;   // config write data
	localparam int STEP_W  = 16;   // tick duration
	localparam int FACT_W  = 24;   // interpolation factor, unsigned q8.16
	localparam int MODE_W  = 4;
	localparam int IDX_W   = 3;
	localparam int SUM_W   = 34;   // base plus step before saturation

	// serial divider
	localparam int DIV_STEPS = 24;
	localparam int CNT_W     = 5;

	localparam logic [FACT_W-1:0] FACTOR_ONE = 24'h010000;
	localparam logic [FACT_W-1:0] FACTOR_MAX = 24'hFFFFFF;

	// opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_RESET = 1'b1;

	// mode flag bits
	localparam int MODE_CONT     = 0;
	localparam int MODE_STOP     = 1;
	localparam int MODE_PINGPONG = 2;
	localparam int MODE_EXT      = 3;

	// config register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_FIRST_X,
		REG_FIRST_Y,
		REG_SECOND_X,
		REG_SECOND_Y,
		REG_SWITCH_DELAY,
		REG_MOVE_DURATION,
		REG_MODE_FLAGS
	} reg_idx_t;

	// config reset values
	localparam logic signed [COORD_W-1:0] RST_FIRST_X  = 23'sd2560;
	localparam logic signed [COORD_W-1:0] RST_FIRST_Y  = 23'sd2560;
	localparam logic signed [COORD_W-1:0] RST_SECOND_X = 23'sd10240;
	localparam logic signed [COORD_W-1:0] RST_SECOND_Y = 23'sd10240;
	localparam logic [REG_W-1:0]          RST_DELAY    = 24'd8000;
	localparam logic [REG_W-1:0]          RST_DURATION = 24'd8000;
	localparam logic [MODE_W-1:0]         RST_MODE     = 4'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FACT,
		ST_MULX,
		ST_MULY,
		ST_FINY,
		ST_PUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // take the input request
		logic exec;      // timers, branch and divider load
		logic div_step;  // one quotient bit
		logic fact;      // saturate, clamp, back and forth
		logic mul_x;     // x product
		logic mul_y;     // commit x, y product
		logic fin_y;     // commit y
		logic push;      // load the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic move;      // this tick runs a continuous move
		logic out_free;  // output register can take a result
	} status_t;

	function automatic logic signed [POS_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(signed'(25'sh07FFFFF));
		lo = SUM_W'(signed'(25'sh1800000));
		if (v > hi)
			return 24'sh7FFFFF;
		else if (v < lo)
			return 24'sh800000;
		else
			return v[POS_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ src/ttps_ctrl.sv @@
// ttps_ctrl: sequencing state machine of the position sequencer
// depends on ttps_pkg; drives ttps_dp through cmd_t and reads status_t
`default_nettype none

module ttps_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  ttps_pkg::status_t  status,
	output ttps_pkg::cmd_t     cmd
);
	import ttps_pkg::*;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	state_t            state_q;
	state_t            state_nx;
	logic [CNT_W-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_EXEC;
			ST_EXEC: state_nx = status.move ? ST_DIV : ST_PUSH;
			ST_DIV:  if (cnt_q == DIV_LAST) state_nx = ST_FACT;
			ST_FACT: state_nx = ST_MULX;
			ST_MULX: state_nx = ST_MULY;
			ST_MULY: state_nx = ST_FINY;
			ST_FINY: state_nx = ST_PUSH;
			ST_PUSH: if (status.out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: cmd.exec     = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_FACT: cmd.fact     = 1'b1;
			ST_MULX: cmd.mul_x    = 1'b1;
			ST_MULY: cmd.mul_y    = 1'b1;
			ST_FINY: cmd.fin_y    = 1'b1;
			ST_PUSH: cmd.push     = status.out_free;
			default: cmd          = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ src/ttps_dp.sv @@
// ttps_dp: datapath of the position sequencer: config, timers, serial divider,
// shared multiplier and output register; depends on ttps_pkg
`default_nettype none

module ttps_dp (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire  [ttps_pkg::IDX_W-1:0]             cfg_index,
	input  wire  [ttps_pkg::REG_W-1:0]             cfg_data,
	input  wire                                    opcode,
	input  wire  [ttps_pkg::STEP_W-1:0]            time_step,
	input  wire                                    timer_connected,
	input  wire                                    start_above,
	input  wire                                    switch_connected,
	input  wire                                    switch_above,
	input  wire                                    switch_below,
	input  wire                                    out_ready,
	output logic                                   out_valid,
	output logic signed [ttps_pkg::POS_W-1:0]      center_x,
	output logic signed [ttps_pkg::POS_W-1:0]      center_y,
	output logic                                   moving_forward,
	input  ttps_pkg::cmd_t                         cmd,
	output ttps_pkg::status_t                      status
);
	import ttps_pkg::*;

	// config registers
	logic signed [COORD_W-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
	logic [REG_W-1:0]          delay_q, dur_q;
	logic [MODE_W-1:0]         mode_q;

	// captured request
	logic              op_q;
	logic [STEP_W-1:0] step_q;
	logic              tconn_q, start_q, sconn_q, sabove_q, sbelow_q;

	// sequencer state
	logic [TIME_W-1:0]        elapsed_q, mt_q;
	logic                     fwd_q, latch_q;
	logic signed [POS_W-1:0]  cur_x_q, cur_y_q;

	// divider, factor and product
	logic [FACT_W-1:0]   rem_q, lo_q, quo_q;
	logic                sat_q;
	logic [FACT_W-1:0]   factor_q;
	logic [2*FACT_W-1:0] prod_q;
	logic                neg_q;

	// output register
	logic                     out_valid_q;
	logic signed [POS_W-1:0]  out_x_q, out_y_q;
	logic                     out_fwd_q;

	// sign-extended targets
	logic signed [POS_W-1:0] fx, fy, sx, sy, dx, dy;
	assign fx = POS_W'(first_x_q);
	assign fy = POS_W'(first_y_q);
	assign sx = POS_W'(second_x_q);
	assign sy = POS_W'(second_y_q);
	assign dx = sx - fx;
	assign dy = sy - fy;

	// timer updates, saturating
	logic [TIME_W:0]   el_sum, mt_sum;
	logic [TIME_W-1:0] el_inc, el_nx, mt_nx;
	logic              ext_mode, early, move, sat_div;

	always_comb begin
		el_sum = {1'b0, elapsed_q} + (TIME_W+1)'(step_q);
		el_inc = el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
		if (tconn_q)
			el_nx = start_q ? el_inc : '0;
		else
			el_nx = elapsed_q;
		mt_sum   = {1'b0, mt_q} + (TIME_W+1)'(step_q);
		mt_nx    = mt_sum[TIME_W] ? '1 : mt_sum[TIME_W-1:0];
		ext_mode = mode_q[MODE_EXT] & sconn_q;
		early    = el_nx < TIME_W'(delay_q);
		move     = (op_q == OP_TICK) && !ext_mode && !early && mode_q[MODE_CONT];
		// quotient above 24 bits exactly when mt >= dur * 256
		sat_div  = mt_nx >= {dur_q, 8'd0};
	end

	// restoring division step
	logic [FACT_W:0] trial, diff;
	logic            ge;
	assign trial = {rem_q, lo_q[FACT_W-1]};
	assign ge    = trial >= {1'b0, dur_q};
	assign diff  = trial - {1'b0, dur_q};

	// factor saturation, clamp at end, back and forth
	logic [FACT_W-1:0] fact_c;
	logic              pp_c;
	always_comb begin
		fact_c = sat_q ? FACTOR_MAX : quo_q;
		if (fact_c > FACTOR_ONE && mode_q[MODE_STOP])
			fact_c = FACTOR_ONE;
		pp_c = (fact_c >= FACTOR_ONE) && mode_q[MODE_PINGPONG];
		if (pp_c)
			fact_c = '0;
	end

	// shared multiplier on the delta magnitude
	logic signed [POS_W-1:0] d_sel;
	logic [POS_W-1:0]        mag;
	logic [2*FACT_W-1:0]     prod_c;
	assign d_sel  = cmd.mul_y ? dy : dx;
	assign mag    = d_sel[POS_W-1] ? POS_W'(-d_sel) : POS_W'(d_sel);
	assign prod_c = (2*FACT_W)'(mag) * (2*FACT_W)'(factor_q);

	// rounding, direction and saturation
	logic [2*FACT_W-1:0]     rnd;
	logic [TIME_W-1:0]       q_mag;
	logic signed [SUM_W-1:0] step_s, base_s, sum_s;
	logic signed [POS_W-1:0] base_p, fin_val;
	always_comb begin
		rnd    = prod_q + (2*FACT_W)'(32768);
		q_mag  = rnd[2*FACT_W-1 -: TIME_W];
		step_s = neg_q ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
		if (cmd.fin_y)
			base_p = fwd_q ? fy : sy;
		else
			base_p = fwd_q ? fx : sx;
		base_s  = SUM_W'(base_p);
		sum_s   = fwd_q ? base_s + step_s : base_s - step_s;
		fin_val = sat24(sum_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q  <= RST_FIRST_X;
			first_y_q  <= RST_FIRST_Y;
			second_x_q <= RST_SECOND_X;
			second_y_q <= RST_SECOND_Y;
			delay_q    <= RST_DELAY;
			dur_q      <= RST_DURATION;
			mode_q     <= RST_MODE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRST_X:       first_x_q  <= cfg_data[COORD_W-1:0];
				REG_FIRST_Y:       first_y_q  <= cfg_data[COORD_W-1:0];
				REG_SECOND_X:      second_x_q <= cfg_data[COORD_W-1:0];
				REG_SECOND_Y:      second_y_q <= cfg_data[COORD_W-1:0];
				REG_SWITCH_DELAY:  delay_q    <= cfg_data;
				REG_MOVE_DURATION: dur_q      <= cfg_data;
				REG_MODE_FLAGS:    mode_q     <= cfg_data[MODE_W-1:0];
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= opcode;
			step_q   <= time_step;
			tconn_q  <= timer_connected;
			start_q  <= start_above;
			sconn_q  <= switch_connected;
			sabove_q <= switch_above;
			sbelow_q <= switch_below;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			mt_q      <= '0;
			fwd_q     <= 1'b1;
			latch_q   <= 1'b0;
			cur_x_q   <= POS_W'(RST_FIRST_X);
			cur_y_q   <= POS_W'(RST_FIRST_Y);
		end else begin
			if (cmd.exec) begin
				if (op_q == OP_RESET) begin
					elapsed_q <= '0;
					mt_q      <= '0;
					fwd_q     <= 1'b1;
					cur_x_q   <= fx;
					cur_y_q   <= fy;
				end else begin
					elapsed_q <= el_nx;
					if (ext_mode) begin
						if (!latch_q && sabove_q) begin
							latch_q <= 1'b1;
							if (cur_x_q == fx && cur_y_q == fy) begin
								cur_x_q <= sx;
								cur_y_q <= sy;
							end else begin
								cur_x_q <= fx;
								cur_y_q <= fy;
							end
						end else if (latch_q && sbelow_q) begin
							latch_q <= 1'b0;
						end
					end else if (early) begin
						cur_x_q <= fx;
						cur_y_q <= fy;
					end else if (!mode_q[MODE_CONT]) begin
						cur_x_q <= sx;
						cur_y_q <= sy;
					end else begin
						mt_q <= mt_nx;
					end
				end
			end
			if (cmd.fact && pp_c) begin
				mt_q  <= '0;
				fwd_q <= ~fwd_q;
			end
			if (cmd.mul_y)
				cur_x_q <= fin_val;
			if (cmd.fin_y)
				cur_y_q <= fin_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rem_q <= mt_nx[TIME_W-1:8];
			lo_q  <= {mt_nx[7:0], 16'd0};
			quo_q <= '0;
			sat_q <= sat_div;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[FACT_W-1:0] : trial[FACT_W-1:0];
			lo_q  <= {lo_q[FACT_W-2:0], 1'b0};
			quo_q <= {quo_q[FACT_W-2:0], ge};
		end
		if (cmd.fact)
			factor_q <= fact_c;
		if (cmd.mul_x || cmd.mul_y) begin
			prod_q <= prod_c;
			neg_q  <= d_sel[POS_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.push)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_x_q   <= cur_x_q;
			out_y_q   <= cur_y_q;
			out_fwd_q <= fwd_q;
		end
	end

	assign status.move     = move;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign center_x       = out_x_q;
	assign center_y       = out_y_q;
	assign moving_forward = out_fwd_q;

endmodule

`default_nettype wire

@@ src/two_target_position_sequencer_top.sv @@
// two_target_position_sequencer_top: top level of the position sequencer
// instantiates ttps_ctrl and ttps_dp; depends on ttps_pkg
`default_nettype none

// each tick request advances a 2-D center between two targets and returns one
// result: the center (signed q.8, saturated to 24 bits) and the direction flag.
// the center holds the first target until the elapsed timer reaches
// switch_delay, then jumps to the second target or, in continuous mode, moves
// along the line over move_duration, clamped, extrapolated or back and forth.
// with external switch mode and a connected switch, each rising switch level
// swaps targets. opcode 1 resets timers, direction and center.
// timing: a request is taken in the idle cycle; a tick that does not run a
// continuous move goes from exec straight to push, while a moving tick also
// passes the radix-2 divider that forms the interpolation factor and one
// shared 24x24 multiplier used once per axis; push waits for a free output.
// one request is in work at a time; a finished result waits in the output
// register while the next request is accepted and computed.
// config writes (cfg_we, cfg_index, cfg_data) take effect at once, indexes above 6
// are ignored; the user must make them while no request is in work; the block does not check.

module two_target_position_sequencer_top (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// config write port
	input  wire                                    cfg_we,
	input  wire  [ttps_pkg::IDX_W-1:0]             cfg_index,
	input  wire  [ttps_pkg::REG_W-1:0]             cfg_data,
	// tick request channel
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire                                    opcode,
	input  wire  [ttps_pkg::STEP_W-1:0]            time_step,
	input  wire                                    timer_connected,
	input  wire                                    start_above,
	input  wire                                    switch_connected,
	input  wire                                    switch_above,
	input  wire                                    switch_below,
	// result channel
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic signed [ttps_pkg::POS_W-1:0]      center_x,
	output logic signed [ttps_pkg::POS_W-1:0]      center_y,
	output logic                                   moving_forward
);
	import ttps_pkg::*;

	// command and status between controller and datapath
	cmd_t    cmd;
	status_t status;

	// sequencing: idle, exec, divide, factor, two multiplies, finish, push
	ttps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// registers, timers, divider, multiplier and output register
	ttps_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.opcode           (opcode),
		.time_step        (time_step),
		.timer_connected  (timer_connected),
		.start_above      (start_above),
		.switch_connected (switch_connected),
		.switch_above     (switch_above),
		.switch_below     (switch_below),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.center_x         (center_x),
		.center_y         (center_y),
		.moving_forward   (moving_forward),
		.cmd              (cmd),
		.status           (status)
	);

endmodule

`default_nettype wire

@@ bench/ttps_center_checker.sv @@
// ttps_center_checker: predicts the sequencer's center for every accepted tick
// request and compares it with the result channel; depends on ttps_pkg only

module ttps_center_checker (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [ttps_pkg::IDX_W-1:0]         cfg_index,
	input  wire  [ttps_pkg::REG_W-1:0]         cfg_data,
	input  wire                                in_valid,
	input  wire                                in_ready,
	input  wire                                opcode,
	input  wire  [ttps_pkg::STEP_W-1:0]        time_step,
	input  wire                                timer_connected,
	input  wire                                start_above,
	input  wire                                switch_connected,
	input  wire                                switch_above,
	input  wire                                switch_below,
	input  wire                                out_valid,
	input  wire                                out_ready,
	input  wire signed [ttps_pkg::POS_W-1:0]   center_x,
	input  wire signed [ttps_pkg::POS_W-1:0]   center_y,
	input  wire                                moving_forward,
	output int                                 mismatches,
	output int                                 outstanding
);
	import ttps_pkg::*;

	localparam logic [FACT_W-1:0] UNIT_FACTOR = 24'h010000;
	localparam logic [FACT_W-1:0] TOP_FACTOR  = 24'hFFFFFF;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic                    fwd;
	} center_t;

	// register copy
	logic signed [COORD_W-1:0] first_x_r, first_y_r, second_x_r, second_y_r;
	logic [REG_W-1:0]          delay_r, dur_r;
	logic [MODE_W-1:0]         mode_r;

	// sequencer state
	logic [TIME_W-1:0]         elapsed, move_time;
	logic                      fwd, latch;
	logic signed [POS_W-1:0]   cur_x, cur_y;

	center_t expected_centers[$];

	function automatic logic [TIME_W-1:0] timer_add(input logic [TIME_W-1:0] a,
			input logic [STEP_W-1:0] b);
		logic [TIME_W:0] s;
		s = a + b;
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
		if (v > 64'sd8388607)
			return 24'sh7FFFFF;
		if (v < -64'sd8388608)
			return 24'sh800000;
		return POS_W'(v);
	endfunction

	// base plus or minus round(factor * delta), half away from zero
	function automatic logic signed [POS_W-1:0] along_line(input longint base,
			input longint delta, input logic [FACT_W-1:0] factor, input logic forward);
		longint unsigned mag;
		longint unsigned q;
		longint stride;
		mag = (delta < 0) ? -delta : delta;
		q = (mag * factor + 64'd32768) >> 16;
		stride = longint'(q);
		if (delta < 0)
			stride = -stride;
		return clamp_pos(forward ? base + stride : base - stride);
	endfunction

	function automatic center_t next_center(input logic op, input logic [STEP_W-1:0] dt,
			input logic tc, input logic sa, input logic sc, input logic swa, input logic swb);
		logic [47:0]       ratio;
		logic [FACT_W-1:0] factor;
		longint            dx, dy;
		dx = longint'(second_x_r) - longint'(first_x_r);
		dy = longint'(second_y_r) - longint'(first_y_r);
		if (op == OP_RESET) begin
			elapsed = '0;
			move_time = '0;
			fwd = 1'b1;
			cur_x = first_x_r;
			cur_y = first_y_r;
		end else begin
			if (tc)
				elapsed = sa ? timer_add(elapsed, dt) : '0;
			if (mode_r[MODE_EXT] && sc) begin
				if (!latch && swa) begin
					latch = 1'b1;
					if (cur_x == first_x_r && cur_y == first_y_r) begin
						cur_x = second_x_r;
						cur_y = second_y_r;
					end else begin
						cur_x = first_x_r;
						cur_y = first_y_r;
					end
				end else if (latch && swb) begin
					latch = 1'b0;
				end
			end else if (elapsed < delay_r) begin
				cur_x = first_x_r;
				cur_y = first_y_r;
			end else if (!mode_r[MODE_CONT]) begin
				cur_x = second_x_r;
				cur_y = second_y_r;
			end else begin
				move_time = timer_add(move_time, dt);
				if (dur_r == '0) begin
					factor = TOP_FACTOR;
				end else begin
					ratio = {move_time, 16'h0000} / dur_r;
					factor = (ratio > 48'hFFFFFF) ? TOP_FACTOR : ratio[FACT_W-1:0];
				end
				if (factor > UNIT_FACTOR && mode_r[MODE_STOP])
					factor = UNIT_FACTOR;
				if (factor >= UNIT_FACTOR && mode_r[MODE_PINGPONG]) begin
					move_time = '0;
					factor = '0;
					fwd = !fwd;
				end
				if (fwd) begin
					cur_x = along_line(first_x_r, dx, factor, 1'b1);
					cur_y = along_line(first_y_r, dy, factor, 1'b1);
				end else begin
					cur_x = along_line(second_x_r, dx, factor, 1'b0);
					cur_y = along_line(second_y_r, dy, factor, 1'b0);
				end
			end
		end
		return '{cur_x, cur_y, fwd};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int      bad;
		center_t want;
		bad = 0;
		if (!arst_n) begin
			first_x_r = 23'sd2560;
			first_y_r = 23'sd2560;
			second_x_r = 23'sd10240;
			second_y_r = 23'sd10240;
			delay_r = 24'd8000;
			dur_r = 24'd8000;
			mode_r = 4'd2;
			elapsed = '0;
			move_time = '0;
			fwd = 1'b1;
			latch = 1'b0;
			cur_x = 24'sd2560;
			cur_y = 24'sd2560;
			expected_centers.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST_X:       first_x_r = cfg_data[COORD_W-1:0];
					REG_FIRST_Y:       first_y_r = cfg_data[COORD_W-1:0];
					REG_SECOND_X:      second_x_r = cfg_data[COORD_W-1:0];
					REG_SECOND_Y:      second_y_r = cfg_data[COORD_W-1:0];
					REG_SWITCH_DELAY:  delay_r = cfg_data;
					REG_MOVE_DURATION: dur_r = cfg_data;
					REG_MODE_FLAGS:    mode_r = cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_centers.size() == 0) begin
					bad++;
					$error("result with none expected: center_x %0d center_y %0d",
						center_x, center_y);
				end else begin
					want = expected_centers.pop_front();
					if (center_x !== want.x || center_y !== want.y
							|| moving_forward !== want.fwd)
						bad++;
					if (center_x !== want.x)
						$error("center_x: expected %0d, got %0d", want.x, center_x);
					if (center_y !== want.y)
						$error("center_y: expected %0d, got %0d", want.y, center_y);
					if (moving_forward !== want.fwd)
						$error("moving_forward: expected %0d, got %0d", want.fwd,
							moving_forward);
				end
			end
			if (in_valid && in_ready)
				expected_centers.insert(expected_centers.size(),
					next_center(opcode, time_step, timer_connected,
					start_above, switch_connected, switch_above, switch_below));
			if (bad != 0)
				mismatches <= mismatches + bad;
			outstanding <= expected_centers.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
// testbench: stimulus and verdict for two_target_position_sequencer_top
// depends on ttps_pkg, the sequencer rtl and ttps_center_checker

module testbench;
	import ttps_pkg::*;

	// one tick request as the sender sees it
	typedef struct packed {
		logic              op;
		logic [STEP_W-1:0] dt;
		logic              tc;
		logic              sa;
		logic              sc;
		logic              swa;
		logic              swb;
	} tick_t;

	localparam logic [IDX_W-1:0] IDX_SPARE = 3'd7;   // no register behind this index
	localparam int TICKS_TARGET = 1750;
	localparam int QUIET_TAIL   = 300;                // last requests go without idling
	localparam int HOLD_CYCLES  = 400;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [REG_W-1:0]      cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  opcode = OP_TICK;
	logic [STEP_W-1:0]     time_step = '0;
	logic                  timer_connected = 1'b0;
	logic                  start_above = 1'b0;
	logic                  switch_connected = 1'b0;
	logic                  switch_above = 1'b0;
	logic                  switch_below = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [POS_W-1:0] center_x;
	logic signed [POS_W-1:0] center_y;
	logic                  moving_forward;

	int   fail_count;
	int   open_results;

	// percent chance of starting an idle burst, per request when sending and per cycle when receiving
	int   idle_pct = 0;
	// one long receiver hold-off, asked for by the stimulus
	bit   hold_req = 1'b0;
	// level of the external switch, walked by the random requests
	logic sw_level = 1'b0;

	always #10 clk = ~clk;

	two_target_position_sequencer_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.time_step        (time_step),
		.timer_connected  (timer_connected),
		.start_above      (start_above),
		.switch_connected (switch_connected),
		.switch_above     (switch_above),
		.switch_below     (switch_below),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.center_x         (center_x),
		.center_y         (center_y),
		.moving_forward   (moving_forward)
	);

	ttps_center_checker u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.time_step        (time_step),
		.timer_connected  (timer_connected),
		.start_above      (start_above),
		.switch_connected (switch_connected),
		.switch_above     (switch_above),
		.switch_below     (switch_below),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.center_x         (center_x),
		.center_y         (center_y),
		.moving_forward   (moving_forward),
		.mismatches       (fail_count),
		.outstanding      (open_results)
	);

	function automatic tick_t tick_of(logic op, logic [STEP_W-1:0] dt, logic tc, logic sa,
			logic sc, logic swa, logic swb);
		return '{op, dt, tc, sa, sc, swa, swb};
	endfunction

	function automatic logic [REG_W-1:0] mode_word(bit cont, bit stop, bit pingpong, bit ext);
		logic [REG_W-1:0] w;
		w = '0;
		w[MODE_CONT] = cont;
		w[MODE_STOP] = stop;
		w[MODE_PINGPONG] = pingpong;
		w[MODE_EXT] = ext;
		return w;
	endfunction

	// target coordinate: mostly in the usual range, sometimes a 23-bit extreme,
	// sometimes raw data whose top bit the block has to drop
	function automatic logic [REG_W-1:0] pick_coord();
		int v;
		case ($urandom_range(0, 9))
			0: return 24'h400000;
			1: return 24'h3FFFFF;
			2: return REG_W'($urandom);
			default: begin
				v = int'($urandom_range(0, 5120000)) - 2560000;
				return REG_W'(v);
			end
		endcase
	endfunction

	// random request; the switch level mostly walks cleanly so that rising levels
	// and releases reach the latch, with some glitchy combinations mixed in
	function automatic tick_t random_tick(int cap, bit ext);
		tick_t t;
		if ($urandom_range(0, 99) < 20)
			sw_level = !sw_level;
		t.op = ($urandom_range(0, 99) < 3) ? OP_RESET : OP_TICK;
		t.dt = STEP_W'($urandom_range(0, cap));
		t.tc = ($urandom_range(0, 99) < 95);
		t.sa = ($urandom_range(0, 99) < 93);
		t.sc = ext ? ($urandom_range(0, 99) < 80) : 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 10) begin
			t.swa = 1'($urandom_range(0, 1));
			t.swb = 1'($urandom_range(0, 1));
		end else begin
			t.swa = sw_level;
			t.swb = !sw_level;
		end
		return t;
	endfunction

	// present one request at a falling edge and hold it until taken;
	// returns at the falling edge after the request was accepted
	task automatic offer_tick(input tick_t t);
		int gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= t.op;
		time_step <= t.dt;
		timer_connected <= t.tc;
		start_above <= t.sa;
		switch_connected <= t.sc;
		switch_above <= t.swa;
		switch_below <= t.swb;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// stop offering and wait for every expected center to come back, so the
	// block is idle and registers may be written
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (open_results != 0);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// new settings for a random phase; every register gets written
	task automatic random_setup(output int cap, output logic [MODE_W-1:0] mode);
		logic [REG_W-1:0] fx, fy, delay, dur;
		fx = pick_coord();
		fy = pick_coord();
		write_reg(REG_FIRST_X, fx);
		write_reg(REG_FIRST_Y, fy);
		// now and then both targets coincide
		if ($urandom_range(0, 9) == 0) begin
			write_reg(REG_SECOND_X, fx);
			write_reg(REG_SECOND_Y, fy);
		end else begin
			write_reg(REG_SECOND_X, pick_coord());
			write_reg(REG_SECOND_Y, pick_coord());
		end
		case ($urandom_range(0, 7))
			0: delay = '0;
			1: delay = '1;
			2, 3: delay = REG_W'($urandom_range(0, 20000));
			default: delay = REG_W'($urandom_range(0, 200000));
		endcase
		write_reg(REG_SWITCH_DELAY, delay);
		case ($urandom_range(0, 9))
			0: dur = '0;
			1: dur = 24'd1;
			2: dur = '1;
			default: dur = REG_W'($urandom_range(1, 100000));
		endcase
		write_reg(REG_MOVE_DURATION, dur);
		mode = MODE_W'($urandom_range(0, 15));
		write_reg(REG_MODE_FLAGS, REG_W'(mode));
		case ($urandom_range(0, 2))
			0: cap = 255;
			1: cap = 4095;
			default: cap = 65535;
		endcase
	endtask

	// result side: random stalls while idling is on, and once a long hold-off
	// so the block backs up and stalls the request side
	initial begin : result_sink
		int gap;
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				gap = $urandom_range(1, 10);
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int               sent;
		int               cap;
		int               phase;
		logic [MODE_W-1:0] mode;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: jump mode with a delay of 8000
		// reset request with every other field set must ignore them
		offer_tick(tick_of(OP_RESET, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		// one short of the delay, then exactly on it
		offer_tick(tick_of(OP_TICK, 16'd7999, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'd1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		// no timer signal: elapsed time holds
		offer_tick(tick_of(OP_TICK, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
		// start level low clears elapsed time, back to the first target
		offer_tick(tick_of(OP_TICK, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		drain_results();

		// zero move duration: factor saturates, stop at end clamps it
		write_reg(REG_SWITCH_DELAY, '0);
		write_reg(REG_MOVE_DURATION, '0);
		write_reg(REG_MODE_FLAGS, mode_word(1'b1, 1'b1, 1'b0, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		drain_results();

		// 23-bit extreme targets, bit 23 of the data set but dropped;
		// extrapolation drives both axes into saturation, x up and y down
		write_reg(REG_FIRST_X, 24'hC00000);
		write_reg(REG_FIRST_Y, 24'h3FFFFF);
		write_reg(REG_SECOND_X, 24'h3FFFFF);
		write_reg(REG_SECOND_Y, 24'hC00000);
		write_reg(REG_MOVE_DURATION, 24'd1);
		write_reg(REG_MODE_FLAGS, mode_word(1'b1, 1'b0, 1'b0, 1'b0));
		offer_tick(tick_of(OP_RESET, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'd1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		drain_results();

		// back and forth: half way, turn at full factor, quarter back, turn again
		write_reg(REG_FIRST_X, 24'd2560);
		write_reg(REG_FIRST_Y, REG_W'(-2560));
		write_reg(REG_SECOND_X, 24'd10240);
		write_reg(REG_SECOND_Y, 24'd7);
		write_reg(REG_MOVE_DURATION, 24'd1000);
		write_reg(REG_MODE_FLAGS, mode_word(1'b1, 1'b0, 1'b1, 1'b0));
		offer_tick(tick_of(OP_RESET, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'd500, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'd500, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'd250, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'd750, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		drain_results();

		// stop at end together with back and forth: clamp, then turn
		write_reg(REG_MODE_FLAGS, mode_word(1'b1, 1'b1, 1'b1, 1'b0));
		// write to the unused index must change nothing
		write_reg(IDX_SPARE, '1);
		offer_tick(tick_of(OP_TICK, 16'd3000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		drain_results();

		// external switch: rising level swaps, latched level holds, release,
		// swap back with both levels high, then switch absent runs the timer
		write_reg(REG_MODE_FLAGS, mode_word(1'b1, 1'b0, 1'b0, 1'b1));
		offer_tick(tick_of(OP_RESET, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'd5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'd5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
		offer_tick(tick_of(OP_TICK, 16'd5, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
		offer_tick(tick_of(OP_TICK, 16'd5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
		offer_tick(tick_of(OP_TICK, 16'd100, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
		drain_results();

		// random phases, each under fresh settings, idling varying per phase
		sent = 0;
		phase = 0;
		while (sent < TICKS_TARGET) begin
			drain_results();
			random_setup(cap, mode);
			if (sent >= TICKS_TARGET - QUIET_TAIL)
				idle_pct <= 0;
			else
				case ($urandom_range(0, 2))
					0: idle_pct <= 0;
					1: idle_pct <= 15;
					default: idle_pct <= 40;
				endcase
			// long receiver hold-off while requests keep coming
			if (phase == 2)
				hold_req <= 1'b1;
			repeat ($urandom_range(80, 180)) begin
				offer_tick(random_tick(cap, mode[MODE_EXT]));
				sent++;
			end
			phase++;
		end

		drain_results();
		// a little extra time to catch any stray result
		repeat (40) @(posedge clk);
		if (fail_count == 0 && open_results == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// backstop well beyond the slowest correct run
	initial begin : watchdog
		#100_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
